/* sv/tlpw_pkg.sv */
// ----------------------------------------------------------------------------
// tlpw_pkg
// Shared widths, codes and sequencer states of the two-level page walk block.
// ----------------------------------------------------------------------------
package tlpw_pkg;

   localparam int PHYS_BYTES_DEF = 65536;

   localparam int VADDR_W    = 32;
   localparam int DATA_W     = 32;
   localparam int NBYTES_W   = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 1;
   localparam int FRAME_W    = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGING_EN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_BASE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DIR_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TBL_ABSENT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_XLATE,
      S_DIR,
      S_TBL,
      S_ACCESS,
      S_DONE
   } state_type;

endpackage

/* sv/tlpw_if.sv */
// ----------------------------------------------------------------------------
// tlpw_if
// Valid/ready channels for access requests and their responses.
// ----------------------------------------------------------------------------
interface tlpw_req_if
   import tlpw_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                func;
   logic [VADDR_W-1:0]  vaddr;
   logic [NBYTES_W-1:0] nbytes;
   logic [DATA_W-1:0]   wdata;

   modport source (output valid, func, vaddr, nbytes, wdata, input ready);
   modport sink   (input valid, func, vaddr, nbytes, wdata, output ready);
endinterface

interface tlpw_rsp_if
   import tlpw_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   rdata;
   logic [STATUS_W-1:0] status;

   modport source (output valid, rdata, status, input ready);
   modport sink   (input valid, rdata, status, output ready);
endinterface

/* sv/tlpw_ram.sv */
// ----------------------------------------------------------------------------
// tlpw_ram
// Single-port byte memory with registered read and a zeroing sweep after
// reset, one byte per cycle.
// ----------------------------------------------------------------------------
module tlpw_ram
   import tlpw_pkg::*;
#(
   parameter int PHYS_BYTES = PHYS_BYTES_DEF,
   localparam int AW = $clog2(PHYS_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic [7:0]    rdata,
   output logic          busy
);

   localparam logic [AW-1:0] LAST = AW'(PHYS_BYTES - 1);

   logic [7:0]    mem [PHYS_BYTES];
   logic [7:0]    rdata_ff;
   logic [AW-1:0] clr_cnt_ff;
   logic          busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_cnt_ff] <= 8'h00;
      end else if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
   assign busy  = busy_ff;

endmodule

/* sv/two_level_page_walk_memory_access.sv */
// ----------------------------------------------------------------------------
// two_level_page_walk_memory_access
// Read or write of 1 to 4 bytes through an optional two-level page walk
// into a little-endian byte memory.
//
//   channel  dir  handshake           payload
//   req_bus  in   valid/ready         func, vaddr, nbytes, wdata
//   rsp_bus  out  valid/ready         rdata, status
//   csr_*    in   csr_wr_en strobe    csr_index, csr_wdata
//
// One item at a time through the single memory port: a byte that stays on the
// page already walked needs no entry read, a byte that needs a walk reads two
// 4-byte entries, directory then table, and then the bytes are read or
// written in turn, between the accept and the completion states.
// After reset the memory is zeroed, with req_bus not ready meanwhile.
// A response waiting on rsp_bus holds completion of the next item only.
// ----------------------------------------------------------------------------
module two_level_page_walk_memory_access
   import tlpw_pkg::*;
#(
   parameter int PHYS_BYTES = PHYS_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tlpw_req_if.sink              req_bus,
   tlpw_rsp_if.source            rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(PHYS_BYTES);

   state_type           state_ff, state_in;
   logic                paging_ff;
   logic [FRAME_W-1:0]  dir_base_ff;

   logic                func_ff, func_in;
   logic [VADDR_W-1:0]  vaddr_ff, vaddr_in;
   logic [NBYTES_W-1:0] n_ff, n_in;
   logic [DATA_W-1:0]   wdata_ff, wdata_in;
   logic [1:0]          idx_ff, idx_in;
   logic [2:0]          rc_ff, rc_in;
   logic [AW-1:0]       pa_ff [4];
   logic [AW-1:0]       pa_in [4];
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [FRAME_W-1:0]  vpn_ff, vpn_in;
   logic                frame_ok_ff, frame_ok_in;
   logic [31:0]         word_ff, word_in;
   logic [31:0]         rd_addr_ff, rd_addr_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0]   rdata_ff, rdata_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_rdata_ff, rsp_rdata_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                mem_we;
   logic [AW-1:0]       mem_addr;
   logic [7:0]          mem_wdata;
   logic [7:0]          mem_q;
   logic                mem_busy;

   logic [VADDR_W-1:0]  va;
   logic                last_byte;
   logic                same_page;
   logic [31:0]         word_full;
   logic [31:0]         chk_base;
   logic [1:0]          chk_off;
   logic                in_range;
   logic [1:0]          rcm1;
   logic                req_fire;

   tlpw_ram #(
      .PHYS_BYTES (PHYS_BYTES)
   ) u_ram (
      .clock (clock),
      .reset (reset),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_q),
      .busy  (mem_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         paging_ff   <= 1'b0;
         dir_base_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PAGING_EN: paging_ff   <= csr_wdata[0];
            CSR_DIR_BASE:  dir_base_ff <= csr_wdata[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   assign va        = vaddr_ff + {30'd0, idx_ff};
   assign last_byte = ({1'b0, idx_ff} == (n_ff - 3'd1));
   assign same_page = frame_ok_ff && (vpn_ff == va[31:12]);
   assign word_full = {mem_q, word_ff[23:0]};
   assign rcm1      = rc_ff[1:0] - 2'd1;
   assign req_fire  = req_bus.valid && req_bus.ready;

   assign req_bus.ready = (state_ff == S_IDLE) && !mem_busy;

   // shared range check: base + offset below the memory size
   always_comb begin
      chk_base = va;
      chk_off  = 2'd0;
      case (state_ff)
         S_XLATE: begin
            if (!paging_ff) begin
               chk_base = va;
            end else if (same_page) begin
               chk_base = {frame_ff, va[11:0]};
            end else begin
               chk_base = {dir_base_ff, va[31:22], 2'b00};
               chk_off  = 2'd3;
            end
         end
         S_DIR: begin
            chk_base = {word_full[31:12], va[21:12], 2'b00};
            chk_off  = 2'd3;
         end
         S_TBL: begin
            chk_base = {word_full[31:12], va[11:0]};
         end
         default: ;
      endcase
   end

   assign in_range = ({1'b0, chk_base} + {31'd0, chk_off}) < 33'(PHYS_BYTES);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      vaddr_in      = vaddr_ff;
      n_in          = n_ff;
      wdata_in      = wdata_ff;
      idx_in        = idx_ff;
      rc_in         = rc_ff;
      pa_in         = pa_ff;
      frame_in      = frame_ff;
      vpn_in        = vpn_ff;
      frame_ok_in   = frame_ok_ff;
      word_in       = word_ff;
      rd_addr_in    = rd_addr_ff;
      status_in     = status_ff;
      rdata_in      = rdata_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_addr      = '0;
      mem_wdata     = wdata_ff[8*rc_ff[1:0] +: 8];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               func_in     = req_bus.func;
               vaddr_in    = req_bus.vaddr;
               wdata_in    = req_bus.wdata;
               if (req_bus.nbytes == 3'd0) begin
                  n_in = 3'd1;
               end else if (req_bus.nbytes > 3'd4) begin
                  n_in = 3'd4;
               end else begin
                  n_in = req_bus.nbytes;
               end
               idx_in      = 2'd0;
               rc_in       = 3'd0;
               frame_ok_in = 1'b0;
               status_in   = ST_OK;
               rdata_in    = '0;
               state_in    = S_XLATE;
            end
         end

         S_XLATE: begin
            if (!in_range) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else if (!paging_ff || same_page) begin
               pa_in[idx_ff] = chk_base[AW-1:0];
               if (last_byte) begin
                  rc_in    = 3'd0;
                  state_in = S_ACCESS;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end else begin
               rd_addr_in = chk_base;
               rc_in      = 3'd0;
               state_in   = S_DIR;
            end
         end

         S_DIR, S_TBL: begin
            mem_addr = rd_addr_ff[AW-1:0];
            if (rc_ff != 3'd0 && rc_ff != 3'd4) begin
               word_in[8*rcm1 +: 8] = mem_q;
            end
            if (rc_ff != 3'd4) begin
               rd_addr_in = rd_addr_ff + 32'd1;
               rc_in      = rc_ff + 3'd1;
            end else if (state_ff == S_DIR) begin
               if (!word_full[0]) begin
                  status_in = ST_DIR_ABSENT;
                  state_in  = S_DONE;
               end else if (!in_range) begin
                  status_in = ST_RANGE;
                  state_in  = S_DONE;
               end else begin
                  rd_addr_in = chk_base;
                  rc_in      = 3'd0;
                  state_in   = S_TBL;
               end
            end else begin
               if (!word_full[0]) begin
                  status_in = ST_TBL_ABSENT;
                  state_in  = S_DONE;
               end else if (!in_range) begin
                  status_in = ST_RANGE;
                  state_in  = S_DONE;
               end else begin
                  pa_in[idx_ff] = chk_base[AW-1:0];
                  frame_in      = word_full[31:12];
                  vpn_in        = va[31:12];
                  frame_ok_in   = 1'b1;
                  rc_in         = 3'd0;
                  if (last_byte) begin
                     state_in = S_ACCESS;
                  end else begin
                     idx_in   = idx_ff + 2'd1;
                     state_in = S_XLATE;
                  end
               end
            end
         end

         S_ACCESS: begin
            mem_addr = pa_ff[rc_ff[1:0]];
            rc_in    = rc_ff + 3'd1;
            if (func_ff) begin
               mem_we = 1'b1;
               if (rc_ff == n_ff - 3'd1) begin
                  state_in = S_DONE;
               end
            end else begin
               if (rc_ff != 3'd0) begin
                  rdata_in[8*rcm1 +: 8] = mem_q;
               end
               if (rc_ff == n_ff) begin
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_rdata_in  = rdata_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      vaddr_ff      <= vaddr_in;
      n_ff          <= n_in;
      wdata_ff      <= wdata_in;
      idx_ff        <= idx_in;
      rc_ff         <= rc_in;
      pa_ff         <= pa_in;
      frame_ff      <= frame_in;
      vpn_ff        <= vpn_in;
      frame_ok_ff   <= frame_ok_in;
      word_ff       <= word_in;
      rd_addr_ff    <= rd_addr_in;
      status_ff     <= status_in;
      rdata_ff      <= rdata_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.rdata  = rsp_rdata_ff;
   assign rsp_bus.status = rsp_status_ff;

endmodule
